// File: rtl/core/keyboard_report_to_key_events_core_assert.svh
// Assertion macros for the keyboard report decoder core.
// Expects signals named clk and rst in the scope of use.
`ifndef KEYBOARD_REPORT_TO_KEY_EVENTS_CORE_ASSERT_SVH
`define KEYBOARD_REPORT_TO_KEY_EVENTS_CORE_ASSERT_SVH

// same-cycle implication
`define KBDEV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kbdev: same-cycle check failed");

// next-cycle implication
`define KBDEV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kbdev: next-cycle check failed");

`endif

// File: rtl/core/kbdev_pkg.sv
// Shared types, constants and keycode mapping for the keyboard report decoder.
// No dependencies.
`default_nettype none

package kbdev_pkg;

  localparam int KEYS       = 6;
  localparam int MAX_EVENTS = KEYS + 1;
  localparam int EV_IDX_W   = $clog2(MAX_EVENTS);

  localparam int KC_W      = 8;
  localparam int MOD_W     = 8;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 3;
  localparam int CHAR_W    = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd400;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd45;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENTER  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BKSP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ESCAPE = 3'd5;

  localparam logic [KC_W-1:0] KC_NONE  = 8'h00;
  localparam logic [KC_W-1:0] KC_A     = 8'h04;
  localparam logic [KC_W-1:0] KC_Z     = 8'h1d;
  localparam logic [KC_W-1:0] KC_1     = 8'h1e;
  localparam logic [KC_W-1:0] KC_0     = 8'h27;
  localparam logic [KC_W-1:0] KC_ENTER = 8'h28;
  localparam logic [KC_W-1:0] KC_ESC   = 8'h29;
  localparam logic [KC_W-1:0] KC_BKSP  = 8'h2a;
  localparam logic [KC_W-1:0] KC_TAB   = 8'h2b;
  localparam logic [KC_W-1:0] KC_SPACE = 8'h2c;
  localparam logic [KC_W-1:0] KC_RIGHT = 8'h4f;
  localparam logic [KC_W-1:0] KC_LEFT  = 8'h50;

  localparam logic [MOD_W-1:0] MOD_LSHIFT = 8'h02;
  localparam logic [MOD_W-1:0] MOD_RSHIFT = 8'h20;

  typedef struct packed {
    logic [MOD_W-1:0]           mods;
    logic [KEYS-1:0][KC_W-1:0]  keys;
    logic [TIME_W-1:0]          now;
  } report_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [KC_W-1:0]   kc;
    logic              rep;
  } event_t;

  // slot order first, repeat event in the top entry
  typedef struct packed {
    logic [MAX_EVENTS-1:0]   valid;
    event_t [MAX_EVENTS-1:0] ev;
  } batch_t;

  typedef struct packed {
    logic [KEYS-1:0][KC_W-1:0] last_keys;
    logic [MOD_W-1:0]          last_mods;
    logic [KC_W-1:0]           held_key;
    logic [MOD_W-1:0]          hold_mods;
    logic                      held_valid;
    logic [TIME_W-1:0]         deadline;
  } kbd_state_t;

  function automatic logic shift_on(input logic [MOD_W-1:0] mods);
    return |(mods & (MOD_LSHIFT | MOD_RSHIFT));
  endfunction

  // "!@#$%^&*()"
  function automatic logic [CHAR_W-1:0] shifted_digit(input logic [3:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      4'd0:    c = 7'h21;
      4'd1:    c = 7'h40;
      4'd2:    c = 7'h23;
      4'd3:    c = 7'h24;
      4'd4:    c = 7'h25;
      4'd5:    c = 7'h5e;
      4'd6:    c = 7'h26;
      4'd7:    c = 7'h2a;
      4'd8:    c = 7'h28;
      4'd9:    c = 7'h29;
      default: c = '0;
    endcase
    return c;
  endfunction

  // US layout; zero means unmapped
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [KC_W-1:0] kc, input logic sh);
    logic [KC_W-1:0]   off;
    logic [CHAR_W-1:0] c;
    off = kc - KC_A;
    c   = '0;
    if (kc >= KC_A && kc <= KC_Z) begin
      c = sh ? CHAR_W'(8'h41 + off) : CHAR_W'(8'h61 + off);
    end else if (kc >= KC_1 && kc <= KC_0) begin
      off = kc - KC_1;
      if (sh) begin
        c = shifted_digit(off[3:0]);
      end else if (kc == KC_0) begin
        c = 7'h30;
      end else begin
        c = CHAR_W'(8'h31 + off);
      end
    end else begin
      unique case (kc)
        KC_TAB:   c = 7'h09;
        KC_SPACE: c = 7'h20;
        8'h2d:    c = sh ? 7'h5f : 7'h2d;
        8'h2e:    c = sh ? 7'h2b : 7'h3d;
        8'h2f:    c = sh ? 7'h7b : 7'h5b;
        8'h30:    c = sh ? 7'h7d : 7'h5d;
        8'h31:    c = sh ? 7'h7c : 7'h5c;
        8'h33:    c = sh ? 7'h3a : 7'h3b;
        8'h34:    c = sh ? 7'h22 : 7'h27;
        8'h35:    c = sh ? 7'h7e : 7'h60;
        8'h36:    c = sh ? 7'h3c : 7'h2c;
        8'h37:    c = sh ? 7'h3e : 7'h2e;
        8'h38:    c = sh ? 7'h3f : 7'h2f;
        default:  c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic logic special_key(input logic [KC_W-1:0] kc);
    return kc == KC_ENTER || kc == KC_BKSP || kc == KC_RIGHT || kc == KC_LEFT ||
           kc == KC_ESC;
  endfunction

  function automatic event_t make_event(input logic [KC_W-1:0] kc, input logic sh,
                                        input logic rep);
    event_t e;
    e.kc  = kc;
    e.rep = rep;
    e.ch  = '0;
    unique case (kc)
      KC_ESC:   e.kind = KIND_ESCAPE;
      KC_ENTER: e.kind = KIND_ENTER;
      KC_BKSP:  e.kind = KIND_BKSP;
      KC_LEFT:  e.kind = KIND_LEFT;
      KC_RIGHT: e.kind = KIND_RIGHT;
      default: begin
        e.kind = KIND_CHAR;
        e.ch   = to_ascii(kc, sh);
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/kbdev_report_if.sv
// Report channel: valid/ready handshake with the boot keyboard report fields.
// Uses kbdev_pkg for field widths.
`default_nettype none

interface kbdev_report_if;
  logic                        valid;
  logic                        ready;
  logic [kbdev_pkg::MOD_W-1:0]  modifier_bits;
  logic [kbdev_pkg::KC_W-1:0]   key_slot0;
  logic [kbdev_pkg::KC_W-1:0]   key_slot1;
  logic [kbdev_pkg::KC_W-1:0]   key_slot2;
  logic [kbdev_pkg::KC_W-1:0]   key_slot3;
  logic [kbdev_pkg::KC_W-1:0]   key_slot4;
  logic [kbdev_pkg::KC_W-1:0]   key_slot5;
  logic [kbdev_pkg::TIME_W-1:0] time_ms;

  modport source (
    output valid, modifier_bits, key_slot0, key_slot1, key_slot2, key_slot3,
           key_slot4, key_slot5, time_ms,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, key_slot0, key_slot1, key_slot2, key_slot3,
           key_slot4, key_slot5, time_ms,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/kbdev_event_if.sv
// Key event channel: valid/ready handshake with the event fields.
// Uses kbdev_pkg for field widths.
`default_nettype none

interface kbdev_event_if;
  logic                        valid;
  logic                        ready;
  logic [kbdev_pkg::KIND_W-1:0] event_kind;
  logic [kbdev_pkg::CHAR_W-1:0] char_code;
  logic [kbdev_pkg::KC_W-1:0]   key_code;
  logic                        is_repeat;
  logic                        last_event;

  modport source (
    output valid, event_kind, char_code, key_code, is_repeat, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, char_code, key_code, is_repeat, last_event,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/kbdev_decode.sv
// Single-pass decode of one report against the held state: new presses,
// hold tracking and the repeat decision. Depends on kbdev_pkg.
`default_nettype none

module kbdev_decode (
  input  kbdev_pkg::report_t                rpt,
  input  kbdev_pkg::kbd_state_t             st,
  input  logic [kbdev_pkg::CFG_W-1:0]       repeat_delay,
  input  logic [kbdev_pkg::CFG_W-1:0]       repeat_interval,
  output kbdev_pkg::batch_t                 batch,
  output kbdev_pkg::kbd_state_t             st_next
);
  import kbdev_pkg::*;

  logic              changed;
  logic              sh_now;
  logic [KEYS-1:0]   seen;
  logic [KEYS-1:0]   new_press;
  logic [KEYS-1:0]   hold;
  logic              new_hold;
  logic [KC_W-1:0]   hold_key;
  logic              down;
  logic              due;
  logic [TIME_W-1:0] since;
  logic              hv;
  logic [KC_W-1:0]   hk;
  logic [MOD_W-1:0]  hm;
  logic              rep_ok;

  always_comb begin
    changed  = rpt.mods != st.last_mods;
    sh_now   = shift_on(rpt.mods);
    hold_key = st.held_key;
    batch    = '0;
    for (int i = 0; i < KEYS; i++) begin
      seen[i] = 1'b0;
      for (int j = 0; j < KEYS; j++) begin
        if (st.last_keys[j] == rpt.keys[i]) seen[i] = 1'b1;
      end
      new_press[i]   = rpt.keys[i] != KC_NONE && !seen[i];
      hold[i]        = new_press[i] && !changed;
      batch.valid[i] = new_press[i] && (!changed || special_key(rpt.keys[i])) &&
                       (special_key(rpt.keys[i]) || to_ascii(rpt.keys[i], sh_now) != '0);
      batch.ev[i]    = make_event(rpt.keys[i], sh_now, 1'b0);
      // later slots win the hold
      if (hold[i]) hold_key = rpt.keys[i];
    end
    new_hold = |hold;

    hk = hold_key;
    hm = new_hold ? rpt.mods : st.hold_mods;
    hv = new_hold || st.held_valid;

    down = new_hold;
    for (int i = 0; i < KEYS; i++) begin
      if (rpt.keys[i] == st.held_key) down = 1'b1;
    end

    // a fresh deadline is now + delay, so it is due only with zero delay
    since = rpt.now - st.deadline;
    due   = new_hold ? (repeat_delay == '0) : !since[TIME_W-1];

    rep_ok = hk == KC_BKSP || hk == KC_LEFT || hk == KC_RIGHT ||
             to_ascii(hk, shift_on(hm)) != '0;
    batch.ev[KEYS] = make_event(hk, shift_on(hm), 1'b1);

    st_next           = st;
    st_next.last_keys = rpt.keys;
    st_next.last_mods = rpt.mods;
    st_next.held_key  = hk;
    st_next.hold_mods = hm;
    st_next.held_valid = hv;
    st_next.deadline  = new_hold ? rpt.now + TIME_W'(repeat_delay) : st.deadline;

    if (hv) begin
      if (!down) begin
        st_next.held_valid = 1'b0;
      end else if (due) begin
        batch.valid[KEYS] = rep_ok;
        st_next.deadline  = rpt.now + TIME_W'(repeat_interval);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kbdev_emit.sv
// Result register holding one report's events; sends them lowest slot first,
// one per cycle while the sink is ready. Depends on kbdev_pkg and kbdev_event_if.
`default_nettype none

module kbdev_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  kbdev_pkg::batch_t  batch,
  output logic               free,
  kbdev_event_if.source      key_event
);
  import kbdev_pkg::*;

  logic [MAX_EVENTS-1:0]   mask;
  event_t [MAX_EVENTS-1:0] evs;
  logic [MAX_EVENTS-1:0]   sel;
  logic [MAX_EVENTS-1:0]   remaining;
  logic [EV_IDX_W-1:0]     idx;
  logic                    take;
  event_t                  cur;

  always_comb begin
    sel       = mask & (~mask + 1'b1);
    remaining = mask & ~sel;
    idx       = '0;
    for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
      if (mask[i]) idx = EV_IDX_W'(i);
    end
    cur  = evs[idx];
    take = (|mask) && key_event.ready;
    free = (mask == '0) || (take && remaining == '0);
  end

  assign key_event.valid      = |mask;
  assign key_event.event_kind = cur.kind;
  assign key_event.char_code  = cur.ch;
  assign key_event.key_code   = cur.kc;
  assign key_event.is_repeat  = cur.rep;
  assign key_event.last_event = remaining == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= batch.valid;
    end else if (take) begin
      mask <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evs <= batch.ev;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/keyboard_report_to_key_events_core.sv
// An accepted report's events become valid once it moves from input to result register.
// Throughput: one report per cycle with at most one event each while the sink is ready;
// reports with more events hold the output; the result register sends one event a cycle.
// The input register takes the next report while events still drain.
// Reset (synchronous, rst high) clears history and held key, sets delay 400 and interval 45.
`default_nettype none

module keyboard_report_to_key_events_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [kbdev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbdev_pkg::CFG_W-1:0]      cfg_wdata,
  kbdev_report_if.sink                     report,
  kbdev_event_if.source                    key_event
);
  import kbdev_pkg::*;

  `include "keyboard_report_to_key_events_core_assert.svh"

  logic [CFG_W-1:0] repeat_delay;
  logic [CFG_W-1:0] repeat_interval;
  report_t          rpt;
  logic             rpt_full;
  kbd_state_t       st;
  kbd_state_t       st_next;
  batch_t           batch;
  logic             emit_free;
  logic             in_move;
  logic             in_take;

  assign in_move      = rpt_full && emit_free;
  assign report.ready = !rpt_full || emit_free;
  assign in_take      = report.valid && report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= REPEAT_DELAY_RST;
      repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_REPEAT_DELAY) repeat_delay <= cfg_wdata;
      if (cfg_index == REG_REPEAT_INTERVAL) repeat_interval <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_full <= 1'b0;
    end else if (in_take) begin
      rpt_full <= 1'b1;
    end else if (in_move) begin
      rpt_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rpt.mods    <= report.modifier_bits;
      rpt.keys[0] <= report.key_slot0;
      rpt.keys[1] <= report.key_slot1;
      rpt.keys[2] <= report.key_slot2;
      rpt.keys[3] <= report.key_slot3;
      rpt.keys[4] <= report.key_slot4;
      rpt.keys[5] <= report.key_slot5;
      rpt.now     <= report.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_move) begin
      st <= st_next;
    end
  end

  kbdev_decode u_decode (
    .rpt             (rpt),
    .st              (st),
    .repeat_delay    (repeat_delay),
    .repeat_interval (repeat_interval),
    .batch           (batch),
    .st_next         (st_next)
  );

  kbdev_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (in_move),
    .batch     (batch),
    .free      (emit_free),
    .key_event (key_event)
  );

  // a waiting item is never dropped while the result register is busy
  `KBDEV_ASSERT_NEXT(a_item_kept, rpt_full && !emit_free, rpt_full)
  // the last event of a report empties the result register unless a new one loads
  `KBDEV_ASSERT_NEXT(a_last_drains,
    key_event.valid && key_event.ready && key_event.last_event && !in_move,
    !key_event.valid)
  // a repeat event only comes from a key that stays held
  `KBDEV_ASSERT_NOW(a_repeat_held, in_move && batch.valid[KEYS], st_next.held_valid)

endmodule

`default_nettype wire
